[rtl/hbpwm_pkg.sv]
// Package with the shared widths, command codes and register indexes of the H-bridge PWM.
`default_nettype none

package hbpwm_pkg;

   localparam int FUNC_W    = 2;
   localparam int DUTY_W    = 8;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 7;
   localparam int MAG_W     = 7;

   // Number of PWM steps in one period; the step counter runs 0..STEPS_PER_PERIOD.
   localparam logic [STEP_W-1:0] STEPS_PER_PERIOD = STEP_W'(100);
   localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);
   localparam logic signed [DUTY_W-1:0] DUTY_MIN = -DUTY_W'(100);

   localparam logic [CSR_W-1:0] CENT_TICK_PERIOD_RESET = CSR_W'(10);
   localparam logic [CSR_W-1:0] DEAD_TIME_TICKS_RESET  = CSR_W'(2);

   // Command codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DUTY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BRAKE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CENT_TICK_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_TIME_TICKS  = 1'd1;

   typedef logic signed [DUTY_W-1:0] duty_type;

endpackage

`default_nettype wire

[rtl/hbpwm_if.sv]
// Valid/ready channel interfaces for the command items and the pin result items.
`default_nettype none

interface hbpwm_req_if;
   import hbpwm_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   duty_type            duty;

   modport source (output valid, output func, output duty, input ready);
   modport sink   (input valid, input func, input duty, output ready);
endinterface

interface hbpwm_rsp_if;
   import hbpwm_pkg::*;

   logic     valid;
   logic     ready;
   logic     pin_a;
   logic     pin_b;
   duty_type duty_now;

   modport source (output valid, output pin_a, output pin_b, output duty_now, input ready);
   modport sink   (input valid, input pin_a, input pin_b, input duty_now, output ready);
endinterface

`default_nettype wire

[rtl/h_bridge_pwm_with_dead_time.sv]
// Top level of the H-bridge PWM driver with dead time insertion.
`default_nettype none

// H-bridge PWM driver. Every item on the req channel is a tick, a set-duty
// command or a brake command, and every accepted item yields exactly one
// result item on rsp that reports the two bridge pin levels and the duty
// now in force (zero while braking). Ticks are divided by a prescaler that
// reloads from cent_tick_period; each prescaler expiry advances a step
// counter through 0..100. During steps 1..100 the active pin drops once the
// step exceeds the duty magnitude, or, while braking, both pins toggle
// together. At the end of a period the pin for the duty's sign is driven
// high, unless the opposite pin is still high: then both pins drop and the
// prescaler is loaded with dead_time_ticks to give the bridge time to turn
// off. Set-duty values beyond +-100 are clamped; func code 3 changes
// nothing. The block takes one item per clock while results drain: the
// state update and the result are formed combinationally and held in a
// result register; a new item is accepted whenever it is empty or being
// emptied, so a result appears the cycle after its item. Configuration
// registers are written through csr_we/csr_index/csr_wdata and should only
// be changed while no item is in flight.
module h_bridge_pwm_with_dead_time (
   input  wire                                  clock,
   input  wire                                  reset,
   hbpwm_req_if.sink                            req,
   hbpwm_rsp_if.source                          rsp,
   input  wire                                  csr_we,
   input  wire  [hbpwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [hbpwm_pkg::CSR_W-1:0]          csr_wdata
);
   import hbpwm_pkg::*;

   // Configuration registers.
   logic [CSR_W-1:0]  cent_tick_period_ff;
   logic [CSR_W-1:0]  dead_time_ticks_ff;

   // PWM state.
   logic [CSR_W-1:0]  prescale_count_ff, prescale_count_in;
   logic [STEP_W-1:0] step_count_ff,     step_count_in;
   duty_type          duty_store_ff,     duty_store_in;
   logic              brake_on_ff,       brake_on_in;
   logic              pin_a_level_ff,    pin_a_level_in;
   logic              pin_b_level_ff,    pin_b_level_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_pin_a_ff;
   logic              rsp_pin_b_ff;
   duty_type          rsp_duty_now_ff;

   logic              req_accept;
   logic [STEP_W-1:0] step_next;
   logic [MAG_W-1:0]  duty_mag;
   duty_type          duty_clamped;

   // The result register frees up in the same cycle it is read out.
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   assign step_next = step_count_ff + STEP_W'(1);
   assign duty_mag  = duty_store_ff[DUTY_W-1] ? MAG_W'(-duty_store_ff) : MAG_W'(duty_store_ff);

   always_comb begin
      if (req.duty > DUTY_MAX) begin
         duty_clamped = DUTY_MAX;
      end else if (req.duty < DUTY_MIN) begin
         duty_clamped = DUTY_MIN;
      end else begin
         duty_clamped = req.duty;
      end
   end

   // Next state for one item.
   always_comb begin
      prescale_count_in = prescale_count_ff;
      step_count_in     = step_count_ff;
      duty_store_in     = duty_store_ff;
      brake_on_in       = brake_on_ff;
      pin_a_level_in    = pin_a_level_ff;
      pin_b_level_in    = pin_b_level_ff;
      case (req.func)
         FUNC_TICK: begin
            if (prescale_count_ff != '0) begin
               prescale_count_in = prescale_count_ff - CSR_W'(1);
            end else begin
               prescale_count_in = cent_tick_period_ff;
               if (step_count_ff < STEPS_PER_PERIOD) begin
                  step_count_in = step_next;
                  if (brake_on_ff) begin
                     // Braking toggles both bridge pins in step.
                     if (pin_a_level_ff || pin_b_level_ff) begin
                        pin_a_level_in = 1'b0;
                        pin_b_level_in = 1'b0;
                     end else begin
                        pin_a_level_in = 1'b1;
                        pin_b_level_in = 1'b1;
                     end
                  end else if (duty_store_ff != '0 && step_next > duty_mag) begin
                     pin_a_level_in = 1'b0;
                     pin_b_level_in = 1'b0;
                  end
               end else begin
                  step_count_in  = '0;
                  pin_a_level_in = 1'b0;
                  pin_b_level_in = 1'b0;
                  if (duty_store_ff[DUTY_W-1]) begin
                     // Reverse drive; wait out dead time if forward is still on.
                     if (pin_a_level_ff) begin
                        prescale_count_in = dead_time_ticks_ff;
                     end else begin
                        pin_b_level_in = 1'b1;
                     end
                  end else if (duty_store_ff != '0) begin
                     if (pin_b_level_ff) begin
                        prescale_count_in = dead_time_ticks_ff;
                     end else begin
                        pin_a_level_in = 1'b1;
                     end
                  end
               end
            end
         end
         FUNC_DUTY: begin
            duty_store_in = duty_clamped;
            brake_on_in   = 1'b0;
         end
         FUNC_BRAKE: begin
            brake_on_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cent_tick_period_ff <= CENT_TICK_PERIOD_RESET;
         dead_time_ticks_ff  <= DEAD_TIME_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CENT_TICK_PERIOD: cent_tick_period_ff <= csr_wdata;
            REG_DEAD_TIME_TICKS:  dead_time_ticks_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_count_ff <= '0;
         step_count_ff     <= '0;
         duty_store_ff     <= '0;
         brake_on_ff       <= 1'b0;
         pin_a_level_ff    <= 1'b0;
         pin_b_level_ff    <= 1'b0;
      end else if (req_accept) begin
         prescale_count_ff <= prescale_count_in;
         step_count_ff     <= step_count_in;
         duty_store_ff     <= duty_store_in;
         brake_on_ff       <= brake_on_in;
         pin_a_level_ff    <= pin_a_level_in;
         pin_b_level_ff    <= pin_b_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pin_a_ff    <= pin_a_level_in;
         rsp_pin_b_ff    <= pin_b_level_in;
         rsp_duty_now_ff <= brake_on_in ? duty_type'(0) : duty_store_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.pin_a    = rsp_pin_a_ff;
   assign rsp.pin_b    = rsp_pin_b_ff;
   assign rsp.duty_now = rsp_duty_now_ff;

   // The step counter never leaves 0..100.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_count_ff <= STEPS_PER_PERIOD)
      else $error("step counter out of range");

   // A brake item always reports a zero duty.
   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      req_accept && req.func == FUNC_BRAKE |=> rsp.duty_now == duty_type'(0))
      else $error("brake item did not report zero duty");

   // A tick on a running prescaler only counts it down.
   a_prescale_down: assert property (@(posedge clock) disable iff (reset)
      req_accept && req.func == FUNC_TICK && prescale_count_ff != '0
      |=> prescale_count_ff == $past(prescale_count_ff) - CSR_W'(1)
          && step_count_ff == $past(step_count_ff))
      else $error("prescaler did not count down");

   // The stored duty stays within the clamp limits.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_store_ff <= DUTY_MAX && duty_store_ff >= DUTY_MIN)
      else $error("stored duty out of range");

endmodule

`default_nettype wire
